@@ rtl/qbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbt_pkg: shared types and constants of the quadratic Bezier tessellator
// Datapath widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package qbt_pkg;

    localparam int DET_W = 6;               // detail count
    localparam int DEN_W = 2 * DET_W;       // detail squared
    localparam int DIV_W = 42;              // first/second difference numerators
    localparam int ACC_W = 44;              // quotient part of the accumulators
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // value = q * den + r, 0 <= r < den
    typedef struct packed {
        logic signed [ACC_W-1:0] q;
        logic [DEN_W-1:0]        r;
    } qr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_INIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_start;
        logic init_acc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_pt;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/qbt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbt_div: iterative signed floor divider
// Restoring division, one quotient bit per cycle, floor quotient and
// non-negative remainder.
// ----------------------------------------------------------------------------
module qbt_div
    import qbt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quot,
    output logic [DEN_W-1:0]        rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]     mag_reg, mag_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DEN_W:0]       rem_sh;
    logic                 qbit;

    always_comb
    begin
        rem_sh    = {rem_reg, mag_reg[DIV_W-1]};
        qbit      = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(DIV_W - 1);
            neg_next  = dividend[DIV_W-1];
            mag_next  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[DIV_W-2:0], qbit};
            rem_next = qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // floor correction for negative dividends
    always_comb
    begin
        if (neg_reg && rem_reg != '0)
        begin
            quot = $signed(~mag_reg);
            rem  = den_reg - rem_reg;
        end
        else if (neg_reg)
        begin
            quot = $signed(-mag_reg);
            rem  = rem_reg;
        end
        else
        begin
            quot = $signed(mag_reg);
            rem  = rem_reg;
        end
    end

    assign done = done_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem < den_reg))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");

endmodule

@@ rtl/qbt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbt_datapath: setup, forward-difference accumulators and output register
// Forms the difference terms, divides them by detail squared and steps the
// exact quotient/remainder accumulators one curve point per command.
// ----------------------------------------------------------------------------
module qbt_datapath
    import qbt_pkg::*;
#(
    parameter int MAX_DETAIL = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic signed [31:0] p0_x,
    input  logic signed [31:0] p0_y,
    input  logic signed [31:0] p1_x,
    input  logic signed [31:0] p1_y,
    input  logic signed [31:0] p2_x,
    input  logic signed [31:0] p2_y,
    input  logic [DET_W-1:0]   detail,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic               last
);

    function automatic qr_t qr_add(input qr_t u, input qr_t v, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] rs;
        logic           cy;
        qr_t            res;
        rs    = {1'b0, u.r} + {1'b0, v.r};
        cy    = (rs >= {1'b0, den});
        res.r = cy ? DEN_W'(rs - {1'b0, den}) : rs[DEN_W-1:0];
        res.q = u.q + v.q + $signed({{(ACC_W-1){1'b0}}, cy});
        return res;
    endfunction

    // nearest, ties away from zero, saturated
    function automatic logic signed [31:0] qr_round(input qr_t v, input logic [DEN_W-1:0] den);
        logic [DEN_W:0]          r2;
        logic                    up;
        logic signed [ACC_W-1:0] s;
        r2 = {v.r, 1'b0};
        up = v.q[ACC_W-1] ? (r2 > {1'b0, den}) : (r2 >= {1'b0, den});
        s  = v.q + $signed({{(ACC_W-1){1'b0}}, up});
        if (s > ACC_W'(S32_MAX))
            return S32_MAX;
        else if (s < ACC_W'(S32_MIN))
            return S32_MIN;
        else
            return s[31:0];
    endfunction

    logic signed [31:0]      ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [DET_W-1:0]        d_reg, d_next;
    logic [DEN_W-1:0]        dsq_reg;
    logic signed [DIV_W-1:0] n1x_reg, n1x_next, n2x_reg, n2x_next;
    logic signed [DIV_W-1:0] n1y_reg, n1y_next, n2y_reg, n2y_next;
    logic signed [32:0]      diff_x, diff_y;
    logic signed [33:0]      k_x, k_y;
    logic signed [DIV_W-1:0] m_x, m_y;

    qr_t                     ptx_reg, ptx_next, pty_reg, pty_next;
    qr_t                     d1x_reg, d1x_next, d1y_reg, d1y_next;
    qr_t                     d2x_reg, d2y_reg;
    logic [DET_W-1:0]        i_reg, i_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [31:0]      point_x_reg, point_y_reg;
    logic                    last_reg;

    logic                    dn_1x, dn_2x, dn_1y, dn_2y;
    logic signed [DIV_W-1:0] q_1x, q_2x, q_1y, q_2y;
    logic [DEN_W-1:0]        r_1x, r_2x, r_1y, r_2y;

    // detail clamp
    always_comb
    begin
        if (detail == '0)
            d_next = DET_W'(1);
        else if (detail > DET_W'(MAX_DETAIL))
            d_next = DET_W'(MAX_DETAIL);
        else
            d_next = detail;
    end

    // num(i) = D*a + i*2d(b-a) + i^2*(a-2b+c), D = d^2
    always_comb
    begin
        diff_x   = 33'(bx_reg) - 33'(ax_reg);
        diff_y   = 33'(by_reg) - 33'(ay_reg);
        k_x      = 34'(ax_reg) + 34'(cx_reg) - (34'(bx_reg) <<< 1);
        k_y      = 34'(ay_reg) + 34'(cy_reg) - (34'(by_reg) <<< 1);
        m_x      = DIV_W'(diff_x) * $signed({1'b0, d_reg, 1'b0});
        m_y      = DIV_W'(diff_y) * $signed({1'b0, d_reg, 1'b0});
        n1x_next = m_x + DIV_W'(k_x);
        n1y_next = m_y + DIV_W'(k_y);
        n2x_next = DIV_W'(k_x) <<< 1;
        n2y_next = DIV_W'(k_y) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ax_reg <= p0_x;
            ay_reg <= p0_y;
            bx_reg <= p1_x;
            by_reg <= p1_y;
            cx_reg <= p2_x;
            cy_reg <= p2_y;
            d_reg  <= d_next;
        end
        if (cmd.prep)
        begin
            dsq_reg <= d_reg * d_reg;
            n1x_reg <= n1x_next;
            n1y_reg <= n1y_next;
            n2x_reg <= n2x_next;
            n2y_reg <= n2y_next;
        end
    end

    qbt_div u_div_1x (.clk, .rst_n, .start(cmd.div_start), .dividend(n1x_reg),
                      .divisor(dsq_reg), .done(dn_1x), .quot(q_1x), .rem(r_1x));
    qbt_div u_div_2x (.clk, .rst_n, .start(cmd.div_start), .dividend(n2x_reg),
                      .divisor(dsq_reg), .done(dn_2x), .quot(q_2x), .rem(r_2x));
    qbt_div u_div_1y (.clk, .rst_n, .start(cmd.div_start), .dividend(n1y_reg),
                      .divisor(dsq_reg), .done(dn_1y), .quot(q_1y), .rem(r_1y));
    qbt_div u_div_2y (.clk, .rst_n, .start(cmd.div_start), .dividend(n2y_reg),
                      .divisor(dsq_reg), .done(dn_2y), .quot(q_2y), .rem(r_2y));

    always_comb
    begin
        ptx_next = ptx_reg;
        pty_next = pty_reg;
        d1x_next = d1x_reg;
        d1y_next = d1y_reg;
        i_next   = i_reg;
        if (cmd.init_acc)
        begin
            ptx_next = '{q: ACC_W'(ax_reg), r: '0};
            pty_next = '{q: ACC_W'(ay_reg), r: '0};
            d1x_next = '{q: ACC_W'(q_1x), r: r_1x};
            d1y_next = '{q: ACC_W'(q_1y), r: r_1y};
            i_next   = '0;
        end
        else if (cmd.emit)
        begin
            ptx_next = qr_add(ptx_reg, d1x_reg, dsq_reg);
            pty_next = qr_add(pty_reg, d1y_reg, dsq_reg);
            d1x_next = qr_add(d1x_reg, d2x_reg, dsq_reg);
            d1y_next = qr_add(d1y_reg, d2y_reg, dsq_reg);
            i_next   = i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ptx_reg <= ptx_next;
        pty_reg <= pty_next;
        d1x_reg <= d1x_next;
        d1y_reg <= d1y_next;
        i_reg   <= i_next;
        if (cmd.init_acc)
        begin
            d2x_reg <= '{q: ACC_W'(q_2x), r: r_2x};
            d2y_reg <= '{q: ACC_W'(q_2y), r: r_2y};
        end
        if (cmd.emit)
        begin
            point_x_reg <= qr_round(ptx_reg, dsq_reg);
            point_y_reg <= qr_round(pty_reg, dsq_reg);
            last_reg    <= (i_reg == d_reg);
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign sts.div_done = dn_1x & dn_2x & dn_1y & dn_2y;
    assign sts.last_pt  = (i_reg == d_reg);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;

    a_first_is_p0: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && i_reg == '0) |->
            (ptx_reg.q == ACC_W'(ax_reg) && ptx_reg.r == '0 &&
             pty_reg.q == ACC_W'(ay_reg) && pty_reg.r == '0))
        else $error("first point differs from start point");

    a_last_is_p2: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_pt) |->
            (ptx_reg.q == ACC_W'(cx_reg) && ptx_reg.r == '0 &&
             pty_reg.q == ACC_W'(cy_reg) && pty_reg.r == '0))
        else $error("last point differs from end point");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted point not presented");

endmodule

@@ rtl/qbt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbt_ctrl: segment sequencer
// Accepts a segment, runs setup and division, then steps out one point per
// free output slot until the final point.
// ----------------------------------------------------------------------------
module qbt_ctrl
    import qbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_PREP;
            ST_PREP:     state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (sts.div_done) state_next = ST_INIT;
            ST_INIT:     state_next = ST_EMIT;
            ST_EMIT:     if (sts.out_free && sts.last_pt) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_PREP:     cmd.prep      = 1'b1;
            ST_DIV_GO:   cmd.div_start = 1'b1;
            ST_DIV_WAIT: cmd           = '0;
            ST_INIT:     cmd.init_acc  = 1'b1;
            ST_EMIT:     cmd.emit      = sts.out_free;
            default:     cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT || state_reg == ST_EMIT) |-> sts.div_done)
        else $error("points stepped without division results");

endmodule

@@ rtl/quadratic_bezier_tessellator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_tessellator_top: quadratic Bezier segment to point list
// Input channel: one transaction carries P0, P1, P2 (signed Q16.16) and a
//   detail count d, clamped to 1..MAX_DETAIL (0 acts as 1).
// Output channel: d+1 transactions, point (x, y) at t = i/d for i = 0..d,
//   rounded to nearest (ties away from zero); last marks t = 1.
// Flow: the input transaction is followed by setup, then four signed
//   floor divisions by d^2 that run in parallel at one quotient bit per
//   cycle, then the accumulator setup and the first point.
// Throughput: one point per cycle after that, while the output is not
//   stalled. The input is stalled until the final point has been loaded
//   into the output register.
// Stall: a stalled output holds its point; point generation pauses until
//   the output register is free again.
// Reset: returns to idle, drops the output valid and clears the divider control; no other state.
// ----------------------------------------------------------------------------
module quadratic_bezier_tessellator_top
    import qbt_pkg::*;
#(
    parameter int MAX_DETAIL = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] p0_x,
    input  logic signed [31:0] p0_y,
    input  logic signed [31:0] p1_x,
    input  logic signed [31:0] p1_y,
    input  logic signed [31:0] p2_x,
    input  logic signed [31:0] p2_y,
    input  logic [DET_W-1:0]   detail,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic               last
);

    cmd_t cmd;
    sts_t sts;

    qbt_ctrl u_ctrl (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .sts,
        .cmd
    );

    qbt_datapath #(
        .MAX_DETAIL(MAX_DETAIL)
    ) u_datapath (
        .clk,
        .rst_n,
        .cmd,
        .sts,
        .p0_x,
        .p0_y,
        .p1_x,
        .p1_y,
        .p2_x,
        .p2_y,
        .detail,
        .out_stall,
        .out_valid,
        .point_x,
        .point_y,
        .last
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of quadratic_bezier_tessellator_top
// Sends quadratic Bezier segments, directed corner cases first and then
// random ones, with random gaps on the input and random stalls on the output.
// A scoreboard expands each accepted segment into its exact rounded curve
// points and checks every output transaction against them in order.
// ----------------------------------------------------------------------------
module tb;
    import qbt_pkg::*;

    localparam int MAX_DETAIL   = 63;
    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_SEGS  = 440;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic signed [31:0] x0, y0, x1, y1, x2, y2;
        logic [DET_W-1:0]   det;
    } bezier_seg_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               end_pt;
    } curve_point_t;

    class bezier_scoreboard;
        curve_point_t expected_points[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // exact rational blend, rounded to nearest, ties away from zero
        function logic signed [31:0] blend(longint a, longint b, longint c,
                                           longint i, longint d);
            longint num, mag, den, q;
            num = (d - i) * (d - i) * a + 2 * i * (d - i) * b + i * i * c;
            den = d * d;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            if (num < 0)
                q = -q;
            if (q > longint'(S32_MAX))
                q = longint'(S32_MAX);
            if (q < longint'(S32_MIN))
                q = longint'(S32_MIN);
            return q[31:0];
        endfunction

        function void note_segment(bezier_seg_t s);
            longint       d;
            curve_point_t p;
            d = (s.det == 0) ? 1 : longint'(s.det);
            if (d > MAX_DETAIL)
                d = MAX_DETAIL;
            for (longint i = 0; i <= d; i++)
            begin
                p.x      = blend(s.x0, s.x1, s.x2, i, d);
                p.y      = blend(s.y0, s.y1, s.y2, i, d);
                p.end_pt = (i == d);
                expected_points.push_back(p);
            end
        endfunction

        function void compare_field(string name, longint expv, longint actv);
            if (expv != actv)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expv, actv);
            end
        endfunction

        function void check_point(logic signed [31:0] x, logic signed [31:0] y,
                                  logic end_pt);
            curve_point_t p;
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point, expected none, actual (%0d, %0d)",
                         $time, x, y);
                return;
            end
            p = expected_points.pop_front();
            compare_field("point_x", p.x, x);
            compare_field("point_y", p.y, y);
            compare_field("last", p.end_pt, end_pt);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;
    logic [DET_W-1:0]   detail;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last;

    bezier_scoreboard sb;
    bit               calm;
    bit               hold_pending;

    quadratic_bezier_tessellator_top #(
        .MAX_DETAIL (MAX_DETAIL)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .p0_x      (p0_x),
        .p0_y      (p0_y),
        .p1_x      (p1_x),
        .p1_y      (p1_y),
        .p2_x      (p2_x),
        .p2_y      (p2_y),
        .detail    (detail),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic logic signed [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0, 1: return r;
            2: return {{12{r[19]}}, r[19:0]};
            3: return $urandom_range(1) ? S32_MAX - $urandom_range(3)
                                        : S32_MIN + $urandom_range(3);
            4: return $signed(32'($urandom_range(8))) - 32'sd4;
            default: return {{4{r[27]}}, r[27:0]};
        endcase
    endfunction

    function automatic bezier_seg_t make_seg(logic signed [31:0] x0, y0, x1, y1,
                                             x2, y2, logic [DET_W-1:0] det);
        bezier_seg_t s;
        s.x0 = x0; s.y0 = y0;
        s.x1 = x1; s.y1 = y1;
        s.x2 = x2; s.y2 = y2;
        s.det = det;
        return s;
    endfunction

    task automatic send_segment(bezier_seg_t s);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        p0_x     <= s.x0;
        p0_y     <= s.y0;
        p1_x     <= s.x1;
        p1_y     <= s.y1;
        p2_x     <= s.x2;
        p2_y     <= s.y2;
        detail   <= s.det;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_segment(s);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_point(point_x, point_y, last);
    end

    initial
    begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        bezier_seg_t s;
        sb           = new();
        calm         = 1'b0;
        hold_pending = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        p0_x         <= '0;
        p0_y         <= '0;
        p1_x         <= '0;
        p1_y         <= '0;
        p2_x         <= '0;
        p2_y         <= '0;
        detail       <= '0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero detail, endpoints, extremes, rounding ties
        send_segment(make_seg(0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(100, -200, 300, -400, 500, -600, 0));
        send_segment(make_seg(S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                              S32_MAX, S32_MAX, 63));
        send_segment(make_seg(S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                              S32_MIN, S32_MIN, 63));
        send_segment(make_seg(S32_MIN, S32_MAX, S32_MAX, S32_MIN,
                              S32_MIN, S32_MAX, 2));
        send_segment(make_seg(S32_MAX, S32_MIN, S32_MIN, S32_MAX,
                              S32_MAX, S32_MIN, 63));
        send_segment(make_seg(S32_MIN, S32_MAX, S32_MIN, S32_MAX,
                              S32_MAX, S32_MIN, 62));
        send_segment(make_seg(1, -1, 0, 0, 1, -1, 2));
        send_segment(make_seg(1, -1, 0, 0, 0, 0, 2));
        send_segment(make_seg(-1, 1, 1, -1, 0, 0, 2));
        send_segment(make_seg(3, -3, -2, 2, 1, -1, 3));
        send_segment(make_seg(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                              -32'sh0004_0000, -32'sh0005_0000, 32'sh0006_0000, 1));
        send_segment(make_seg(S32_MAX, 0, S32_MIN, 0, S32_MAX, 0, 1));
        send_segment(make_seg(0, S32_MIN, 0, S32_MAX, 0, S32_MIN, 32));
        send_segment(make_seg(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), 21));
        send_segment(make_seg(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), 42));
        send_segment(make_seg(-7, 7, 5, -5, 3, -3, 7));
        send_segment(make_seg(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                              32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 16));

        for (int n = 0; n < RANDOM_SEGS; n++)
        begin
            calm = (n >= 150 && n < 260);
            if (n == 60)
                hold_pending = 1'b1;
            s = make_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(),
                         $urandom_range(1) ? $urandom_range(63) : $urandom_range(6));
            send_segment(s);
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.errors == 0 && sb.expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
